// File: hw/rtl/thick_line_to_triangles_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thick line expander
// Concurrent checks on clk_i, switched off when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef THICK_LINE_TO_TRIANGLES_TOP_ASSERT_SVH
`define THICK_LINE_TO_TRIANGLES_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TLTT_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TLTT_ASSERT(name, prop) \
  `TLTT_ASSERT_MSG(name, prop, "tltt check failed")
`else
`define TLTT_ASSERT_MSG(name, prop, msg)
`define TLTT_ASSERT(name, prop)
`endif
`endif

// File: hw/rtl/tltt_pkg.sv
// ----------------------------------------------------------------------------
// tltt_pkg
// Types and constants shared by the thick line expander.
// ----------------------------------------------------------------------------
package tltt_pkg;

  localparam int CoordWidth   = 32;
  localparam int AbsWidth     = CoordWidth + 1;
  localparam int NrmWidth     = 31;
  localparam int MagWidth     = (AbsWidth > NrmWidth) ? AbsWidth : NrmWidth;
  localparam int ThickWidth   = 32;
  localparam int LenWidth     = 32;
  localparam int DenWidth     = LenWidth + 1;
  localparam int RemWidth     = DenWidth + 1;
  localparam int QuoWidth     = 32;
  localparam int NumWidth     = NrmWidth + ThickWidth;
  localparam int SqWidth      = 64;
  localparam int OffWidth     = QuoWidth + 2;
  localparam int SumWidth     = ((CoordWidth > OffWidth) ? CoordWidth : OffWidth) + 1;
  localparam int ColWidth     = 8;
  localparam int ZWidth       = 16;
  localparam int VnWidth      = 3;
  localparam int CntWidth     = $clog2(QuoWidth);
  localparam int AddrWidth    = 3;
  localparam int DataWidth    = 32;
  localparam int FifoDepth    = 2;
  localparam int FifoPtrWidth = $clog2(FifoDepth);
  localparam int FifoCntWidth = $clog2(FifoDepth + 1);

  localparam logic [0:0]         RegZLayer = 1'b0;
  localparam logic [VnWidth-1:0] VertLast  = 3'd5;

  typedef struct packed {
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic signed [CoordWidth-1:0] end_x;
    logic signed [CoordWidth-1:0] end_y;
    logic [ColWidth-1:0]          red_in;
    logic [ColWidth-1:0]          green_in;
    logic [ColWidth-1:0]          blue_in;
    logic [ColWidth-1:0]          alpha_in;
    logic [ThickWidth-1:0]        thickness;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] vert_x;
    logic signed [CoordWidth-1:0] vert_y;
    logic [ZWidth-1:0]            vert_z;
    logic [ColWidth-1:0]          red_out;
    logic [ColWidth-1:0]          green_out;
    logic [ColWidth-1:0]          blue_out;
    logic [ColWidth-1:0]          alpha_out;
    logic [VnWidth-1:0]           vertex_number;
    logic                         last;
  } out_item_t;

  // classified segment, front to core
  typedef struct packed {
    in_item_t             seg;
    logic [MagWidth-1:0]  ax;
    logic [MagWidth-1:0]  ay;
    logic                 dy_pos;
    logic                 dx_neg;
  } fe_item_t;

  // segment with its offset, core to emitter
  typedef struct packed {
    in_item_t                   seg;
    logic signed [OffWidth-1:0] nx;
    logic signed [OffWidth-1:0] ny;
  } seg_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_NORM, CS_SQX, CS_SQY, CS_SUM, CS_SQRT,
    CS_NUMX, CS_NUMY, CS_DINIT, CS_DIV, CS_FIN
  } core_state_e;

endpackage

// File: hw/rtl/tltt_fifo.sv
// ----------------------------------------------------------------------------
// tltt_fifo
// Short queue of classified segments between front and core.
// ----------------------------------------------------------------------------
module tltt_fifo import tltt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  fe_item_t     push_data_i,
  input  logic         pop_i,
  output fe_item_t     pop_data_o,
  output fifo_status_t status_o
);

  fe_item_t                mem_q [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_q, rd_q;
  logic [FifoCntWidth-1:0] cnt_q;
  logic                    do_push, do_pop;

  assign status_o.full  = (cnt_q == FifoCntWidth'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FifoPtrWidth'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FifoPtrWidth'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/tltt_front.sv
// ----------------------------------------------------------------------------
// tltt_front
// Forms the segment deltas, their magnitudes and the offset signs.
// ----------------------------------------------------------------------------
module tltt_front import tltt_pkg::*; (
  input  in_item_t item_i,
  output fe_item_t item_o
);

  logic signed [AbsWidth-1:0] dx, dy;
  logic [AbsWidth-1:0]        ax, ay;

  always_comb begin
    dx = AbsWidth'(item_i.end_x) - AbsWidth'(item_i.start_x);
    dy = AbsWidth'(item_i.end_y) - AbsWidth'(item_i.start_y);
    ax = dx[AbsWidth-1] ? AbsWidth'(-dx) : AbsWidth'(dx);
    ay = dy[AbsWidth-1] ? AbsWidth'(-dy) : AbsWidth'(dy);
    // zero length: take direction (1,0)
    if (dx == '0 && dy == '0) begin
      ax = AbsWidth'(1);
    end
    item_o.seg    = item_i;
    item_o.ax     = MagWidth'(ax);
    item_o.ay     = MagWidth'(ay);
    item_o.dy_pos = !dy[AbsWidth-1] && (dy != '0);
    item_o.dx_neg = dx[AbsWidth-1];
  end

endmodule

// File: hw/rtl/tltt_core.sv
// ----------------------------------------------------------------------------
// tltt_core
// Normalises the deltas, takes the square root and forms the rounded offset.
// ----------------------------------------------------------------------------
module tltt_core import tltt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fifo_status_t fifo_st_i,
  input  fe_item_t     fifo_data_i,
  output logic         pop_o,
  output logic         seg_valid_o,
  output seg_item_t    seg_o,
  input  logic         seg_take_i
);

  core_state_e state_q, state_d;

  fe_item_t              cur_q;
  logic [MagWidth-1:0]   ax_q, ay_q, m;
  logic [SqWidth-1:0]    v_q, p_q, r_q, b_q, rb;
  logic [NumWidth-1:0]   numx_q, numy_q, num_prod;
  logic [DenWidth-1:0]   den_q, rx_q, ry_q;
  logic [QuoWidth-1:0]   qx_q, qy_q, numx_lo, numy_lo;
  logic [CntWidth-1:0]   cnt_q;
  logic [NrmWidth-1:0]   sq_op, nm_op;
  logic [2*NrmWidth-1:0] sq_prod;
  logic [4:0]            shamt;
  logic                  shr, norm_done, fin_load;
  logic [DenWidth:0]     stx, sty;
  logic [QuoWidth:0]     magx, magy;
  logic signed [OffWidth-1:0] magx_s, magy_s;
  seg_item_t             seg_q;
  logic                  seg_valid_q;

  function automatic logic [DenWidth:0] div_step(logic [DenWidth-1:0] rem, logic nb,
                                                 logic [DenWidth-1:0] den);
    logic [RemWidth-1:0] sh;
    sh = {rem, nb};
    if (sh >= RemWidth'(den)) begin
      return {DenWidth'(sh - RemWidth'(den)), 1'b1};
    end
    return {DenWidth'(sh), 1'b0};
  endfunction

  // normalising shift: one coarse step a cycle
  always_comb begin
    m         = (ax_q > ay_q) ? ax_q : ay_q;
    norm_done = ((m >> NrmWidth) == '0) && m[NrmWidth-1];
    shr       = ((m >> NrmWidth) != '0);
    if (shr) begin
      priority if ((m >> (NrmWidth + 16)) != '0) shamt = 5'd16;
      else if ((m >> (NrmWidth + 8)) != '0)      shamt = 5'd8;
      else if ((m >> (NrmWidth + 4)) != '0)      shamt = 5'd4;
      else if ((m >> (NrmWidth + 2)) != '0)      shamt = 5'd2;
      else                                       shamt = 5'd1;
    end else begin
      priority if ((m >> (NrmWidth - 16)) == '0) shamt = 5'd16;
      else if ((m >> (NrmWidth - 8)) == '0)      shamt = 5'd8;
      else if ((m >> (NrmWidth - 4)) == '0)      shamt = 5'd4;
      else if ((m >> (NrmWidth - 2)) == '0)      shamt = 5'd2;
      else                                       shamt = 5'd1;
    end
  end

  always_comb begin
    sq_op    = (state_q == CS_SQX) ? ax_q[NrmWidth-1:0] : ay_q[NrmWidth-1:0];
    sq_prod  = sq_op * sq_op;
    nm_op    = (state_q == CS_NUMX) ? ay_q[NrmWidth-1:0] : ax_q[NrmWidth-1:0];
    num_prod = nm_op * cur_q.seg.thickness;
    rb       = r_q + b_q;
    numx_lo  = numx_q[QuoWidth-1:0];
    numy_lo  = numy_q[QuoWidth-1:0];
    stx      = div_step(rx_q, numx_lo[cnt_q], den_q);
    sty      = div_step(ry_q, numy_lo[cnt_q], den_q);
    magx     = QuoWidth'(qx_q) + (({rx_q, 1'b0} >= RemWidth'(den_q)) ? 1'b1 : 1'b0);
    magy     = QuoWidth'(qy_q) + (({ry_q, 1'b0} >= RemWidth'(den_q)) ? 1'b1 : 1'b0);
    magx_s   = $signed(OffWidth'(magx));
    magy_s   = $signed(OffWidth'(magy));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:  if (pop_o) state_d = CS_NORM;
      CS_NORM:  if (norm_done) state_d = CS_SQX;
      CS_SQX:   state_d = CS_SQY;
      CS_SQY:   state_d = CS_SUM;
      CS_SUM:   state_d = CS_SQRT;
      CS_SQRT:  if (b_q[0]) state_d = CS_NUMX;
      CS_NUMX:  state_d = CS_NUMY;
      CS_NUMY:  state_d = CS_DINIT;
      CS_DINIT: state_d = CS_DIV;
      CS_DIV:   if (cnt_q == '0) state_d = CS_FIN;
      CS_FIN:   if (fin_load) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == CS_IDLE) && !fifo_st_i.empty;
    fin_load = (state_q == CS_FIN) && (!seg_valid_q || seg_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      seg_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        seg_valid_q <= 1'b1;
      end else if (seg_take_i) begin
        seg_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CS_IDLE: begin
        if (pop_o) begin
          cur_q <= fifo_data_i;
          ax_q  <= fifo_data_i.ax;
          ay_q  <= fifo_data_i.ay;
        end
      end
      CS_NORM: begin
        if (!norm_done) begin
          ax_q <= shr ? (ax_q >> shamt) : (ax_q << shamt);
          ay_q <= shr ? (ay_q >> shamt) : (ay_q << shamt);
        end
      end
      CS_SQX: v_q <= SqWidth'(sq_prod);
      CS_SQY: p_q <= SqWidth'(sq_prod);
      CS_SUM: begin
        v_q <= v_q + p_q;
        r_q <= '0;
        b_q <= SqWidth'(1) << (SqWidth - 2);
      end
      CS_SQRT: begin
        if (v_q >= rb) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      CS_NUMX: numx_q <= num_prod;
      CS_NUMY: begin
        numy_q <= num_prod;
        den_q  <= {r_q[LenWidth-1:0], 1'b0};
      end
      CS_DINIT: begin
        rx_q  <= DenWidth'(numx_q[NumWidth-1:QuoWidth]);
        ry_q  <= DenWidth'(numy_q[NumWidth-1:QuoWidth]);
        qx_q  <= '0;
        qy_q  <= '0;
        cnt_q <= CntWidth'(QuoWidth - 1);
      end
      CS_DIV: begin
        rx_q  <= stx[DenWidth:1];
        ry_q  <= sty[DenWidth:1];
        qx_q  <= {qx_q[QuoWidth-2:0], stx[0]};
        qy_q  <= {qy_q[QuoWidth-2:0], sty[0]};
        cnt_q <= cnt_q - 1'b1;
      end
      CS_FIN: begin
        if (fin_load) begin
          seg_q.seg <= cur_q.seg;
          seg_q.nx  <= cur_q.dy_pos ? -magx_s : magx_s;
          seg_q.ny  <= cur_q.dx_neg ? -magy_s : magy_s;
        end
      end
      default: ;
    endcase
  end

  assign seg_valid_o = seg_valid_q;
  assign seg_o       = seg_q;

endmodule

// File: hw/rtl/tltt_emit.sv
// ----------------------------------------------------------------------------
// tltt_emit
// Emits the six vertices of a segment through a registered output stage.
// ----------------------------------------------------------------------------
module tltt_emit import tltt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seg_valid_i,
  input  seg_item_t         seg_i,
  output logic              seg_take_o,
  input  logic [ZWidth-1:0] z_layer_i,
  output logic              out_valid_o,
  output out_item_t         out_data_o,
  input  logic              out_stall_i
);

  seg_item_t          hold_q;
  logic               hold_valid_q, out_valid_q, emit, emit_last, use_end, neg;
  logic [VnWidth-1:0] k_q;
  out_item_t          out_q, vert;
  logic signed [CoordWidth-1:0] px, py;
  logic signed [SumWidth-1:0]   sx, sy;

  function automatic logic signed [CoordWidth-1:0] sat(logic signed [SumWidth-1:0] v);
    logic [SumWidth-CoordWidth:0] up;
    up = v[SumWidth-1:CoordWidth-1];
    if (&up || ~|up) begin
      return v[CoordWidth-1:0];
    end
    return v[SumWidth-1] ? {1'b1, {(CoordWidth-1){1'b0}}} : {1'b0, {(CoordWidth-1){1'b1}}};
  endfunction

  // order: end-n, start+n, end+n, end-n, start+n, start-n
  always_comb begin
    use_end = (k_q == 3'd0) || (k_q == 3'd2) || (k_q == 3'd3);
    neg     = (k_q == 3'd0) || (k_q == 3'd3) || (k_q == VertLast);
    px      = use_end ? hold_q.seg.end_x : hold_q.seg.start_x;
    py      = use_end ? hold_q.seg.end_y : hold_q.seg.start_y;
    sx      = neg ? SumWidth'(px) - SumWidth'(hold_q.nx) : SumWidth'(px) + SumWidth'(hold_q.nx);
    sy      = neg ? SumWidth'(py) - SumWidth'(hold_q.ny) : SumWidth'(py) + SumWidth'(hold_q.ny);
    vert.vert_x        = sat(sx);
    vert.vert_y        = sat(sy);
    vert.vert_z        = z_layer_i;
    vert.red_out       = hold_q.seg.red_in;
    vert.green_out     = hold_q.seg.green_in;
    vert.blue_out      = hold_q.seg.blue_in;
    vert.alpha_out     = hold_q.seg.alpha_in;
    vert.vertex_number = k_q;
    vert.last          = (k_q == VertLast);
  end

  assign emit       = hold_valid_q && (!out_valid_q || !out_stall_i);
  assign emit_last  = emit && (k_q == VertLast);
  assign seg_take_o = seg_valid_i && (!hold_valid_q || emit_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      k_q          <= '0;
    end else begin
      if (seg_take_o) begin
        hold_valid_q <= 1'b1;
      end else if (emit_last) begin
        hold_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        k_q         <= emit_last ? '0 : k_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_take_o) begin
      hold_q <= seg_i;
    end
    if (emit) begin
      out_q <= vert;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/thick_line_to_triangles_top.sv
// ----------------------------------------------------------------------------
// thick_line_to_triangles_top
// Expands a thick line segment into six vertices forming two triangles.
// ----------------------------------------------------------------------------
//  channel   direction  payload     handshake
//  in        input      in_item_t   in_valid_i / in_stall_o
//  out       output     out_item_t  out_valid_o / out_stall_i
//  config    input      z_layer     APB psel/penable/pwrite, pready tied high
//
//  In the core a segment passes through a pop, the normalising shifts,
//  the squares and their sum, 32 square root steps, the products and
//  divider set-up, 32 steps of the two dividers, one bit each, and the
//  hand-over of the offset. The six output beats overlap the next
//  segment's work, so the core's bit-serial loops set the rate.
//  Reset clears the queue, the core state and the output valid flags.
//  A stall on the output holds the vertex register; the queue absorbs
//  input beats meanwhile and stalls the input once full.
// ----------------------------------------------------------------------------
`include "thick_line_to_triangles_top_assert.svh"

module thick_line_to_triangles_top import tltt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  fe_item_t          fe_item, fifo_item;
  fifo_status_t      fifo_st;
  logic              pop, seg_valid, seg_take, in_acc;
  seg_item_t         seg_item;
  logic [ZWidth-1:0] z_layer_q;

  // config register: write on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegZLayer) ? {{(DataWidth - ZWidth){1'b0}}, z_layer_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_layer_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegZLayer)) begin
      z_layer_q <= pwdata[ZWidth-1:0];
    end
  end

  // front: classify and queue, stall only when the queue is full
  assign in_stall_o = fifo_st.full;
  assign in_acc     = in_valid_i && !in_stall_o;

  tltt_front u_front (
    .item_i (in_data_i),
    .item_o (fe_item)
  );

  tltt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (fe_item),
    .pop_i       (pop),
    .pop_data_o  (fifo_item),
    .status_o    (fifo_st)
  );

  // back: offset computation, then vertex emission
  tltt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .fifo_data_i (fifo_item),
    .pop_o       (pop),
    .seg_valid_o (seg_valid),
    .seg_o       (seg_item),
    .seg_take_i  (seg_take)
  );

  tltt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_valid_i (seg_valid),
    .seg_i       (seg_item),
    .seg_take_o  (seg_take),
    .z_layer_i   (z_layer_q),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // vertices of a segment follow one another without gaps
  `TLTT_ASSERT(a_vertex_seq, out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o && (out_data_o.vertex_number == $past(out_data_o.vertex_number) + 3'd1))
  // an accepted beat lands in the queue
  `TLTT_ASSERT(a_queue_fill, in_acc |=> !fifo_st.empty)
  // a finished offset holds until the emitter takes it
  `TLTT_ASSERT(a_seg_hold, seg_valid && !seg_take |=> seg_valid && $stable(seg_item))

endmodule
